// ===== hw/rtl/byte_ring_line_assembler_core_defines.svh =====
// assertion macros for the line assembler
`ifndef BYTE_RING_LINE_ASSEMBLER_CORE_DEFINES_SVH
`define BYTE_RING_LINE_ASSEMBLER_CORE_DEFINES_SVH
`define BRLA_ASSERT_IMPL(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");
`define BRLA_ASSERT_NEXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== hw/rtl/brla_pkg.sv =====
// ----------------------------------------------------------------------------
// brla_pkg
// shared types and constants of the byte ring line assembler
// ----------------------------------------------------------------------------
package brla_pkg;
  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_PUMP  = 2'd1;
  localparam logic [1:0] OP_DEQ   = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_RETURN  = 8'h0D;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PUSH, ST_PUMP_RD, ST_PUMP_WAIT, ST_PUMP_DO,
    ST_DEQ_RD, ST_DEQ_WAIT, ST_DEQ_OUT, ST_DEQ_ONE, ST_CLEAR
  } state_t;

  typedef struct packed {
    logic push;
    logic clear;
    logic pump_rd;
    logic pump_do;
    logic deq_start;
    logic deq_rd;
    logic deq_emit;
    logic deq_one;
  } cmd_t;

  typedef struct packed {
    logic ring_empty;
    logic queue_full;
    logic queue_empty;
    logic line_zero;
    logic last_char;
  } stat_t;
endpackage

// ===== hw/rtl/brla_ram.sv =====
// ----------------------------------------------------------------------------
// brla_ram
// generic single write, single registered read ram
// ----------------------------------------------------------------------------
module brla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/brla_datapath.sv =====
// ----------------------------------------------------------------------------
// brla_datapath
// ring, partial line, line queue and output register
// ----------------------------------------------------------------------------
module brla_datapath #(
  parameter int RING_DEPTH  = 512,
  parameter int QUEUE_LINES = 4,
  parameter int LINE_MAX    = 63
) (
  input  logic            clk,
  input  logic            rst_n,
  input  brla_pkg::cmd_t  cmd,
  output brla_pkg::stat_t stat,
  input  logic [7:0]      byte_in,
  output logic [11:0]     res
);
  localparam int RW = $clog2(RING_DEPTH);
  localparam int QW = (QUEUE_LINES > 1) ? $clog2(QUEUE_LINES) : 1;
  localparam int QD = (QUEUE_LINES > 1) ? QUEUE_LINES : 2;
  localparam int SD = QD * 64;
  localparam int SW = QW + 6;

  logic [RW-1:0] rd_r, rd_nxt, wr_r, wr_nxt;
  logic drop_r, drop_nxt, pbad_r, pbad_nxt;
  logic [5:0] plen_r, plen_nxt, ci_r, ci_nxt;
  logic [QW-1:0] head_r, head_nxt;
  logic [QW:0] cnt_r, cnt_nxt;
  logic [5:0] lens_r [QD];
  logic bads_r [QD];
  logic [5:0] dlen_r;
  logic dbad_r;
  logic [11:0] res_r, res_nxt;
  // during dequeue head_r already points past the line, so line_ra uses saved slot
  logic [QW-1:0] dslot_r;

  logic ring_we;
  logic [7:0] ring_wd, ring_q, line_q;
  logic [RW-1:0] wr_inc, rd_inc;
  logic line_we;
  logic [SW-1:0] line_wa, line_ra;
  logic [QW-1:0] tail;
  logic [QW:0] hsum;

  assign wr_inc = (wr_r == RW'(RING_DEPTH-1)) ? '0 : wr_r + 1'b1;
  assign rd_inc = (rd_r == RW'(RING_DEPTH-1)) ? '0 : rd_r + 1'b1;
  assign hsum = {1'b0, head_r} + cnt_r;
  assign tail = (hsum >= (QW+1)'(QUEUE_LINES)) ? QW'(hsum - (QW+1)'(QUEUE_LINES))
                                               : QW'(hsum);

  brla_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_ring (
    .clk, .we(ring_we), .waddr(wr_r), .wdata(ring_wd), .raddr(rd_r), .rdata(ring_q));
  // partial line is written straight into the tail slot
  brla_ram #(.WIDTH(8), .DEPTH(SD)) u_line (
    .clk, .we(line_we), .waddr(line_wa), .wdata(ring_q), .raddr(line_ra), .rdata(line_q));

  assign line_wa = {tail, plen_r};
  assign line_ra = {dslot_r, ci_r};

  always_comb begin
    rd_nxt = rd_r; wr_nxt = wr_r; drop_nxt = drop_r; pbad_nxt = pbad_r;
    plen_nxt = plen_r; head_nxt = head_r; cnt_nxt = cnt_r; ci_nxt = ci_r;
    res_nxt = res_r; ring_we = 1'b0; ring_wd = byte_in; line_we = 1'b0;
    if (cmd.clear) begin
      rd_nxt = '0; wr_nxt = '0; drop_nxt = 1'b0; pbad_nxt = 1'b0;
      plen_nxt = '0; head_nxt = '0; cnt_nxt = '0;
    end
    if (cmd.push && !(drop_r && byte_in != brla_pkg::CH_NEWLINE)) begin
      drop_nxt = 1'b0;
      if (wr_inc == rd_r) begin
        rd_nxt = wr_r; plen_nxt = '0; pbad_nxt = 1'b1;
        drop_nxt = (byte_in != brla_pkg::CH_NEWLINE);
        if (byte_in == brla_pkg::CH_NEWLINE) begin
          ring_we = 1'b1; wr_nxt = wr_inc;
        end
      end else begin
        ring_we = 1'b1; wr_nxt = wr_inc;
      end
    end
    if (cmd.pump_rd) rd_nxt = rd_inc;
    if (cmd.pump_do) begin
      if (ring_q == brla_pkg::CH_NEWLINE) begin
        cnt_nxt = cnt_r + 1'b1; plen_nxt = '0; pbad_nxt = 1'b0;
      end else if (ring_q == 8'h00) begin
        pbad_nxt = 1'b1;
      end else if (ring_q == brla_pkg::CH_RETURN) begin
        pbad_nxt = pbad_r;
      end else if (plen_r < 6'(LINE_MAX)) begin
        line_we = 1'b1; plen_nxt = plen_r + 1'b1;
      end else begin
        pbad_nxt = 1'b1;
      end
    end
    if (cmd.deq_start) begin
      ci_nxt = '0;
      head_nxt = (head_r == QW'(QUEUE_LINES-1)) ? '0 : head_r + 1'b1;
      cnt_nxt = cnt_r - 1'b1;
    end
    if (cmd.deq_rd) ci_nxt = ci_r + 1'b1;
    if (cmd.deq_emit)
      res_nxt = {(ci_r == dlen_r), 1'b0, dbad_r, 1'b1, line_q};
    if (cmd.deq_one)
      res_nxt = (cnt_r == '0) ? {4'b1100, 8'h00} : {2'b10, bads_r[head_r], 1'b0, 8'h00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= '0; wr_r <= '0; drop_r <= 1'b0; pbad_r <= 1'b0; plen_r <= '0;
      head_r <= '0; cnt_r <= '0;
    end else begin
      rd_r <= rd_nxt; wr_r <= wr_nxt; drop_r <= drop_nxt; pbad_r <= pbad_nxt;
      plen_r <= plen_nxt; head_r <= head_nxt; cnt_r <= cnt_nxt;
    end
    ci_r <= ci_nxt;
    res_r <= res_nxt;
    if (cmd.pump_do && ring_q == brla_pkg::CH_NEWLINE) begin
      lens_r[tail] <= plen_r; bads_r[tail] <= pbad_r;
    end
    if (cmd.deq_start) begin
      dlen_r <= lens_r[head_r]; dbad_r <= bads_r[head_r]; dslot_r <= head_r;
    end
  end

  assign stat.ring_empty  = (rd_r == wr_r);
  assign stat.queue_full  = (cnt_r == (QW+1)'(QUEUE_LINES));
  assign stat.queue_empty = (cnt_r == '0);
  assign stat.line_zero   = (lens_r[head_r] == '0);
  assign stat.last_char   = (ci_r == dlen_r);
  assign res = res_r;
endmodule

// ===== hw/rtl/brla_ctrl.sv =====
// ----------------------------------------------------------------------------
// brla_ctrl
// sequencer for push, pump, dequeue and clear
// ----------------------------------------------------------------------------
`include "byte_ring_line_assembler_core_defines.svh"
module brla_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_req,
  input  logic [1:0]      op,
  output logic            in_rdy,
  output logic            out_vld,
  input  logic            out_rdy,
  input  brla_pkg::stat_t stat,
  output brla_pkg::cmd_t  cmd,
  output logic            res_last
);
  brla_pkg::state_t st_r, st_nxt;
  logic ov_r, ov_nxt, lst_r, lst_nxt;
  logic hs;
  assign hs = in_req && in_rdy;
  assign in_rdy = (st_r == brla_pkg::ST_IDLE) && !ov_r;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      brla_pkg::ST_IDLE:
        if (hs) begin
          case (op)
            brla_pkg::OP_PUSH: st_nxt = brla_pkg::ST_IDLE;
            brla_pkg::OP_PUMP: st_nxt = brla_pkg::ST_PUMP_RD;
            brla_pkg::OP_DEQ:  st_nxt = (stat.queue_empty || stat.line_zero) ?
                                        brla_pkg::ST_DEQ_ONE : brla_pkg::ST_DEQ_RD;
            default:           st_nxt = brla_pkg::ST_IDLE;
          endcase
        end
      brla_pkg::ST_PUMP_RD:
        st_nxt = (stat.ring_empty || stat.queue_full) ? brla_pkg::ST_IDLE
                                                      : brla_pkg::ST_PUMP_WAIT;
      brla_pkg::ST_PUMP_WAIT: st_nxt = brla_pkg::ST_PUMP_DO;
      brla_pkg::ST_PUMP_DO:   st_nxt = brla_pkg::ST_PUMP_RD;
      // next character is read only once the output register is free
      brla_pkg::ST_DEQ_RD:
        if (!ov_r || out_rdy) st_nxt = brla_pkg::ST_DEQ_WAIT;
      brla_pkg::ST_DEQ_WAIT:  st_nxt = brla_pkg::ST_DEQ_OUT;
      brla_pkg::ST_DEQ_OUT:
        st_nxt = stat.last_char ? brla_pkg::ST_IDLE : brla_pkg::ST_DEQ_RD;
      brla_pkg::ST_DEQ_ONE:   st_nxt = brla_pkg::ST_IDLE;
      default:                st_nxt = brla_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    ov_nxt = ov_r && !out_rdy;
    lst_nxt = lst_r;
    case (st_r)
      brla_pkg::ST_IDLE: begin
        cmd.push = hs && (op == brla_pkg::OP_PUSH);
        cmd.clear = hs && (op == brla_pkg::OP_CLEAR);
        if (hs && op == brla_pkg::OP_DEQ) begin
          cmd.deq_one = 1'b1; ov_nxt = stat.queue_empty || stat.line_zero;
          cmd.deq_start = !stat.queue_empty;
        end
      end
      // ram output holds the byte at the old pointer in the next cycle
      brla_pkg::ST_PUMP_WAIT: cmd.pump_rd = 1'b1;
      brla_pkg::ST_PUMP_DO: cmd.pump_do = 1'b1;
      brla_pkg::ST_DEQ_RD: lst_nxt = 1'b0;
      brla_pkg::ST_DEQ_WAIT: cmd.deq_rd = 1'b1;
      brla_pkg::ST_DEQ_OUT: begin
        cmd.deq_emit = 1'b1; ov_nxt = 1'b1; lst_nxt = stat.last_char;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= brla_pkg::ST_IDLE; ov_r <= 1'b0; lst_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ov_r <= ov_nxt; lst_r <= lst_nxt;
    end
  end
  assign out_vld = ov_r;
  assign res_last = lst_r;

  `BRLA_ASSERT_IMPL(a_no_in_while_out, clk, rst_n, out_vld, !in_rdy)
  `BRLA_ASSERT_IMPL(a_one_cmd, clk, rst_n, 1'b1, $onehot0({cmd.push, cmd.clear,
    cmd.pump_rd, cmd.pump_do, cmd.deq_rd, cmd.deq_emit}))
  `BRLA_ASSERT_NEXT(a_emit_shows, clk, rst_n, cmd.deq_emit, out_vld)
endmodule

// ===== hw/rtl/byte_ring_line_assembler_core.sv =====
// ----------------------------------------------------------------------------
// byte_ring_line_assembler_core
// byte ring feeding a line framer with a small queue of finished lines
// ----------------------------------------------------------------------------
// A push or a clear completes straight from the idle state. A pump moves ring
// bytes one at a time through the read, wait and move states, set by the
// registered read of the ring memory. A dequeue of an empty queue or an empty
// line gives a single registered result; otherwise each character passes
// through the read, wait and output states of the line store read port, and a
// character is only read once the previous result has been taken. Input is
// held off while a result waits to be taken.
module byte_ring_line_assembler_core #(
  parameter int RING_DEPTH  = 512,
  parameter int QUEUE_LINES = 4,
  parameter int LINE_MAX    = 63
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // opcode[1:0], byte_value[9:2], zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // line_char[7:0], char_valid, line_overflow,
                                  // queue_empty, zero fill
  output logic        out_tlast
);
  brla_pkg::cmd_t cmd;
  brla_pkg::stat_t stat;
  logic [11:0] res;
  logic lst;

  brla_ctrl u_ctrl (
    .clk, .rst_n, .in_req(in_tvalid), .op(in_tdata[1:0]), .in_rdy(in_tready),
    .out_vld(out_tvalid), .out_rdy(out_tready), .stat, .cmd, .res_last(lst));

  brla_datapath #(.RING_DEPTH(RING_DEPTH), .QUEUE_LINES(QUEUE_LINES),
    .LINE_MAX(LINE_MAX)) u_dp (
    .clk, .rst_n, .cmd, .stat, .byte_in(in_tdata[9:2]), .res);

  assign out_tdata = {5'd0, res[10:0]};
  assign out_tlast = res[11];
  logic unused_bits;
  assign unused_bits = ^in_tdata[15:10] ^ lst;
endmodule
